@@ rtl/integer_to_ascii_digits_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Integer to ASCII digits unit: assertion macros
// Shared property wrappers for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication
`define I2A_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("i2a assertion failed");

// Next-cycle implication
`define I2A_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("i2a assertion failed");

`endif

@@ rtl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII digits: package
// Mode codes, widths, emitter load request and the digit to character map.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned ActW    = 3;
  localparam int unsigned ValW    = 64;
  localparam int unsigned LowW    = 32;
  localparam int unsigned DigW    = 4;
  localparam int unsigned DecDigs = 10;
  localparam int unsigned BcdW    = DecDigs * DigW;
  localparam int unsigned CntW    = 5;

  // Conversion modes
  localparam logic [ActW-1:0] ACT_SDEC = 3'd0;
  localparam logic [ActW-1:0] ACT_UDEC = 3'd1;
  localparam logic [ActW-1:0] ACT_HEXL = 3'd2;
  localparam logic [ActW-1:0] ACT_HEXU = 3'd3;
  localparam logic [ActW-1:0] ACT_PTR  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  // Load request for the emitter: digits left aligned, MS nibble on top
  typedef struct packed {
    logic [ValW-1:0] digits;
    logic [CntW-1:0] cnt;
    logic [1:0]      pfx;
    logic            ptr;
    logic            upper;
  } em_load_t;

  // One digit (0..15) to its ASCII code
  function automatic logic [7:0] dig_char(input logic [DigW-1:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      dig_char = CH_ZERO + d8;
    end else begin
      dig_char = (upper ? CH_UA : CH_LA) + d8 - 8'd10;
    end
  endfunction

endpackage

@@ rtl/i2a_dd.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII digits: serial binary to BCD
// Double dabble on a 32-bit word, one input bit per cycle.
// ----------------------------------------------------------------------------
module i2a_dd (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [i2a_pkg::LowW-1:0] bin_i,
  output logic                   done_o,
  output logic [i2a_pkg::BcdW-1:0] bcd_o
);
  import i2a_pkg::*;

  logic [LowW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d, adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;

  // Add three to every BCD digit of five or more
  always_comb begin
    for (int i = 0; i < DecDigs; i++) begin
      adj[i*DigW +: DigW] = (bcd_q[i*DigW +: DigW] >= 4'd5) ?
                            bcd_q[i*DigW +: DigW] + 4'd3 : bcd_q[i*DigW +: DigW];
    end
  end

  // Shift step and bit counter
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[LowW-1]};
      bin_d = {bin_q[LowW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(LowW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ rtl/i2a_emit.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII digits: character emitter
// Drops leading zero digits one a cycle, then sends prefix and digits
// through the output register, one nibble per character.
// ----------------------------------------------------------------------------
module i2a_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  i2a_pkg::em_load_t req_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        character_o,
  output logic              last_o
);
  import i2a_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SKIP = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [ValW-1:0] dig_q, dig_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      pfx_q, pfx_d;
  logic            ptr_q, ptr_d;
  logic            upper_q, upper_d;
  logic            ov_q, ov_d;
  logic [7:0]      ch_q, ch_d;
  logic            last_q, last_d;
  logic            out_free;
  logic [DigW-1:0] top;

  assign out_free = !ov_q || !out_stall_i;
  assign top      = dig_q[ValW-1 -: DigW];

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    pfx_d   = pfx_q;
    ptr_d   = ptr_q;
    upper_d = upper_q;
    ov_d    = ov_q && out_stall_i;
    ch_d    = ch_q;
    last_d  = last_q;
    case (state_q)
      S_IDLE: begin
        if (load_i) begin
          dig_d   = req_i.digits;
          cnt_d   = req_i.cnt;
          pfx_d   = req_i.pfx;
          ptr_d   = req_i.ptr;
          upper_d = req_i.upper;
          state_d = S_SKIP;
        end
      end
      // Leading zeros; a lone zero digit is kept
      S_SKIP: begin
        if (cnt_q > CntW'(1) && top == '0) begin
          dig_d = {dig_q[ValW-DigW-1:0], {DigW{1'b0}}};
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = S_OUT;
        end
      end
      // Prefix first, then the digits
      S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          if (pfx_q != 2'd0) begin
            ch_d   = ptr_q ? ((pfx_q == 2'd2) ? CH_ZERO : CH_X) : CH_MINUS;
            last_d = 1'b0;
            pfx_d  = pfx_q - 1'b1;
          end else begin
            ch_d   = dig_char(top, upper_q);
            last_d = (cnt_q == CntW'(1));
            dig_d  = {dig_q[ValW-DigW-1:0], {DigW{1'b0}}};
            cnt_d  = cnt_q - 1'b1;
            if (cnt_q == CntW'(1)) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
    pfx_q   <= pfx_d;
    ptr_q   <= ptr_d;
    upper_q <= upper_d;
    ch_q    <= ch_d;
    last_q  <= last_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign character_o = ch_q;
  assign last_o      = last_q;

endmodule

@@ rtl/integer_to_ascii_digits_unit.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII digits unit
// Turns a value into its decimal or hex text, sent one character at a time.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i, in_stall_o, action_i, value_i. Output channel:
// out_valid_o, out_stall_i, character_o, last_o; last_o marks the final
// character of a value's text. Requests move when valid is high and stall
// low. Modes 5 to 7 are taken and give no characters.
// One value is converted at a time. Decimal modes run a bit-serial double
// dabble that hands over its digits once all 32 bits are shifted in; hex and
// pointer modes load their nibbles at once. Leading zero digits then drop
// out one per cycle (over 10 decimal, 8 hex or 16 pointer places), the
// emitter moves to output, and characters leave at one per cycle while the
// output is not stalled. The next value may be taken while the final
// character still waits in the output register. Reset clears the state and
// valid flags; no request is pending afterwards. A stall on the output holds
// the character register and pauses the emitter's output step.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [i2a_pkg::ActW-1:0] action_i,
  input  logic [i2a_pkg::ValW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               character_o,
  output logic                     last_o
);
  import i2a_pkg::*;

  logic            in_acc, em_busy, dd_done, conv_q, conv_d, neg_q, neg_d;
  logic            dd_start, em_load, is_dec, is_hex, neg_in;
  logic [LowW-1:0] low, mag;
  logic [BcdW-1:0] bcd;
  em_load_t        req;

  assign in_stall_o = conv_q || em_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign low        = value_i[LowW-1:0];
  assign is_dec     = (action_i == ACT_SDEC) || (action_i == ACT_UDEC);
  assign is_hex     = (action_i == ACT_HEXL) || (action_i == ACT_HEXU) ||
                      (action_i == ACT_PTR);
  assign neg_in     = (action_i == ACT_SDEC) && low[LowW-1];
  assign mag        = neg_in ? (~low + 1'b1) : low;
  assign dd_start   = in_acc && is_dec;
  assign em_load    = (in_acc && is_hex) || dd_done;

  // Decimal conversion in progress
  always_comb begin
    conv_d = conv_q;
    neg_d  = neg_q;
    if (dd_start) begin
      conv_d = 1'b1;
      neg_d  = neg_in;
    end else if (dd_done) begin
      conv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b0;
    end else begin
      conv_q <= conv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
  end

  // Emitter load request
  always_comb begin
    if (conv_q) begin
      req.digits = {bcd, {(ValW-BcdW){1'b0}}};
      req.cnt    = CntW'(DecDigs);
      req.pfx    = neg_q ? 2'd1 : 2'd0;
      req.ptr    = 1'b0;
      req.upper  = 1'b0;
    end else if (action_i == ACT_PTR) begin
      req.digits = value_i;
      req.cnt    = CntW'(ValW / DigW);
      req.pfx    = 2'd2;
      req.ptr    = 1'b1;
      req.upper  = 1'b0;
    end else begin
      req.digits = {low, {(ValW-LowW){1'b0}}};
      req.cnt    = CntW'(LowW / DigW);
      req.pfx    = 2'd0;
      req.ptr    = 1'b0;
      req.upper  = (action_i == ACT_HEXU);
    end
  end

  i2a_dd u_dd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dd_start),
    .bin_i   (mag),
    .done_o  (dd_done),
    .bcd_o   (bcd)
  );

  i2a_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (em_load),
    .req_i       (req),
    .busy_o      (em_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/i2a_checker.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII digits: port checker
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_digits_unit_defines.svh"

module i2a_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [i2a_pkg::ActW-1:0] action_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [7:0]               character_o,
  input logic                     last_o
);
  import i2a_pkg::*;

  logic       in_take;
  logic [8:0] out_word;
  logic       char_ok;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_word = {character_o, last_o};
  assign char_ok  = (character_o >= 8'h30 && character_o <= 8'h39) ||
                    (character_o >= 8'h61 && character_o <= 8'h66) ||
                    (character_o >= 8'h41 && character_o <= 8'h46) ||
                    character_o == CH_X || character_o == CH_MINUS;

  // A stalled character holds
  `I2A_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

  // A valid mode always keeps the block busy for the next cycle
  `I2A_ASSERT_NEXT(a_busy_after_take, in_take && action_i <= ACT_PTR, in_stall_o)

  // No new value is taken while a text is only partly sent
  `I2A_ASSERT_NOW(a_no_take_mid_text, out_valid_o && !last_o, in_stall_o)

  // Only digits, hex letters, 'x' and '-' appear
  `I2A_ASSERT_NOW(a_char_set, out_valid_o, char_ok)

endmodule

bind integer_to_ascii_digits_unit i2a_checker u_i2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .last_o      (last_o)
);
